// ----- sv/vbd_pkg.sv -----
package vbd_pkg;

	localparam int unsigned MainHdrLen = 26;
	localparam int unsigned FmtLen     = 12;

	localparam logic [7:0] TYPE_FORMAT = 8'h09;
	localparam logic [7:0] TYPE_DATA   = 8'h02;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       raw;
	} vbd_emit_t;

endpackage

// ----- sv/vbd_parser.sv -----
module vbd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	output vbd_pkg::vbd_emit_t emit,
	output logic [31:0]       rate_q,
	output logic [7:0]        bits_q,
	output logic [7:0]        chans_q
);

	typedef enum logic [2:0] {
		PH_MAIN_HDR,
		PH_FIRST_TYPE,
		PH_FMT_SIZE,
		PH_FMT_BODY,
		PH_PAYLOAD,
		PH_BLK_TYPE,
		PH_BLK_SIZE,
		PH_RAW
	} phase_t;

	phase_t      phase_q;
	logic [4:0]  count_q;
	logic [23:0] remain_q;
	logic [23:0] size_q;

	logic [4:0]  count_inc;
	logic [23:0] size_nxt;
	logic [23:0] remain_dec;

	assign count_inc  = count_q + 5'd1;
	assign remain_dec = (remain_q != 24'd0) ? remain_q - 24'd1 : remain_q;

	always_comb begin
		case (count_q)
			5'd0:    size_nxt = {16'd0, byte_in};
			5'd1:    size_nxt = size_q | {8'd0, byte_in, 8'd0};
			default: size_nxt = size_q | {byte_in, 16'd0};
		endcase
	end

	always_comb begin
		emit.valid = 1'b0;
		emit.data  = byte_in;
		emit.raw   = 1'b1;
		case (phase_q)
			PH_FIRST_TYPE: emit.valid = (byte_in != vbd_pkg::TYPE_FORMAT);
			PH_PAYLOAD: begin
				emit.valid = 1'b1;
				emit.raw   = 1'b0;
			end
			PH_BLK_TYPE:   emit.valid = (byte_in != vbd_pkg::TYPE_DATA);
			PH_RAW:        emit.valid = 1'b1;
			default:       emit.valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAIN_HDR;
			count_q  <= 5'd0;
			remain_q <= 24'd0;
			size_q   <= 24'd0;
			rate_q   <= 32'd0;
			bits_q   <= 8'd0;
			chans_q  <= 8'd0;
		end else if (step) begin
			case (phase_q)
				PH_MAIN_HDR: begin
					if (count_inc >= 5'(vbd_pkg::MainHdrLen)) begin
						count_q <= 5'd0;
						phase_q <= PH_FIRST_TYPE;
					end else begin
						count_q <= count_inc;
					end
				end
				PH_FIRST_TYPE: begin
					if (byte_in == vbd_pkg::TYPE_FORMAT) begin
						count_q <= 5'd0;
						phase_q <= PH_FMT_SIZE;
					end else begin
						phase_q <= PH_RAW;
					end
				end
				PH_FMT_SIZE: begin
					size_q <= size_nxt;
					if (count_q >= 5'd2) begin
						remain_q <= (size_nxt >= 24'(vbd_pkg::FmtLen))
							? size_nxt - 24'(vbd_pkg::FmtLen) : 24'd0;
						count_q  <= 5'd0;
						phase_q  <= PH_FMT_BODY;
					end else begin
						count_q <= count_inc;
					end
				end
				PH_FMT_BODY: begin
					case (count_q)
						5'd0: rate_q <= {24'd0, byte_in};
						5'd1: rate_q <= rate_q | {16'd0, byte_in, 8'd0};
						5'd2: rate_q <= rate_q | {8'd0, byte_in, 16'd0};
						5'd3: rate_q <= rate_q | {byte_in, 24'd0};
						5'd4: bits_q <= byte_in;
						5'd5: chans_q <= byte_in;
						default: ;
					endcase
					if (count_inc >= 5'(vbd_pkg::FmtLen)) begin
						count_q <= 5'd0;
						phase_q <= (remain_q != 24'd0) ? PH_PAYLOAD : PH_BLK_TYPE;
					end else begin
						count_q <= count_inc;
					end
				end
				PH_PAYLOAD: begin
					remain_q <= remain_dec;
					if (remain_dec == 24'd0) begin
						phase_q <= PH_BLK_TYPE;
					end
				end
				PH_BLK_TYPE: begin
					if (byte_in == vbd_pkg::TYPE_DATA) begin
						count_q <= 5'd0;
						phase_q <= PH_BLK_SIZE;
					end else begin
						phase_q <= PH_RAW;
					end
				end
				PH_BLK_SIZE: begin
					size_q <= size_nxt;
					if (count_q >= 5'd2) begin
						remain_q <= size_nxt;
						count_q  <= 5'd0;
						phase_q  <= (size_nxt != 24'd0) ? PH_PAYLOAD : PH_BLK_TYPE;
					end else begin
						count_q <= count_inc;
					end
				end
				default: phase_q <= PH_RAW;
			endcase
		end
	end

endmodule

// ----- sv/voc_block_deframer.sv -----
// channel | signals                                               | direction
// input   | in_valid, in_ready, in_byte                           | in
// output  | out_valid, out_ready, out_byte, sample_rate,          | out
//         | sample_bits, channel_count, raw_mode                  |
// One byte per cycle sustained while out_ready stays high: an input register feeds
// the parse step, whose result lands in the output register.
// Header bytes produce no output transaction.
// arst_n clears parse state, format fields and both valid flags.
// A stalled output holds the input register; in_ready drops only when both are full.
module voc_block_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [31:0] sample_rate,
	output logic [7:0]  sample_bits,
	output logic [7:0]  channel_count,
	output logic        raw_mode
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               s2_free;
	logic               step;
	vbd_pkg::vbd_emit_t emit;
	logic [31:0]        rate_q;
	logic [7:0]         bits_q;
	logic [7:0]         chans_q;

	assign s2_free  = !out_valid || out_ready;
	assign step     = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	vbd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.emit    (emit),
		.rate_q  (rate_q),
		.bits_q  (bits_q),
		.chans_q (chans_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_free) begin
			out_valid <= step && emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit.valid) begin
			out_byte      <= emit.data;
			raw_mode      <= emit.raw;
			sample_rate   <= rate_q;
			sample_bits   <= bits_q;
			channel_count <= chans_q;
		end
	end

endmodule

// ----- test/tb_voc_block_deframer.sv -----
`timescale 1ns / 100ps

typedef enum logic [2:0] {
	HDR_SKIP,
	FIRST_TYPE,
	FMT_SIZE,
	FMT_BODY,
	PAYLOAD,
	BLOCK_TYPE,
	BLOCK_SIZE,
	PASS_RAW
} deframe_phase_t;

typedef struct packed {
	logic [7:0]  data;
	logic [31:0] rate;
	logic [7:0]  bits;
	logic [7:0]  chans;
	logic        raw;
} audio_byte_t;

class deframe_scoreboard;
	deframe_phase_t phase;
	logic [4:0]     count;
	logic [23:0]    remaining;
	logic [23:0]    size_acc;
	logic [31:0]    rate;
	logic [7:0]     bits;
	logic [7:0]     chans;
	audio_byte_t    expected_q[$];
	int unsigned    fails;

	function new();
		phase     = HDR_SKIP;
		count     = '0;
		remaining = '0;
		size_acc  = '0;
		rate      = '0;
		bits      = '0;
		chans     = '0;
		fails     = 0;
	endfunction

	function int unsigned pending();
		return expected_q.size();
	endfunction

	function void push_expected(logic [7:0] b, logic raw);
		audio_byte_t e;
		e.data  = b;
		e.rate  = rate;
		e.bits  = bits;
		e.chans = chans;
		e.raw   = raw;
		expected_q.push_back(e);
	endfunction

	// shift in one little-endian size byte; true after the third
	function bit shift_size(logic [7:0] b);
		logic [4:0] k;
		k = count;
		if (k == 0) begin
			size_acc = {16'h0, b};
		end else if (k == 1) begin
			size_acc[15:8] = b;
		end else begin
			size_acc[23:16] = b;
		end
		count = k + 5'd1;
		return k >= 2;
	endfunction

	function void note_input(logic [7:0] b);
		case (phase)
		HDR_SKIP: begin
			count = count + 5'd1;
			if (count >= vbd_pkg::MainHdrLen) begin
				count = '0;
				phase = FIRST_TYPE;
			end
		end
		FIRST_TYPE: begin
			if (b == vbd_pkg::TYPE_FORMAT) begin
				count = '0;
				phase = FMT_SIZE;
			end else begin
				phase = PASS_RAW;
				push_expected(b, 1'b1);
			end
		end
		FMT_SIZE: begin
			if (shift_size(b)) begin
				remaining = (size_acc >= vbd_pkg::FmtLen)
					? size_acc - 24'(vbd_pkg::FmtLen) : 24'h0;
				count = '0;
				phase = FMT_BODY;
			end
		end
		FMT_BODY: begin
			if (count == 0) begin
				rate = {24'h0, b};
			end else if (count < 4) begin
				rate[count * 8 +: 8] = b;
			end else if (count == 4) begin
				bits = b;
			end else if (count == 5) begin
				chans = b;
			end
			count = count + 5'd1;
			if (count >= vbd_pkg::FmtLen) begin
				count = '0;
				phase = (remaining != 0) ? PAYLOAD : BLOCK_TYPE;
			end
		end
		PAYLOAD: begin
			if (remaining != 0)
				remaining = remaining - 24'd1;
			if (remaining == 0)
				phase = BLOCK_TYPE;
			push_expected(b, 1'b0);
		end
		BLOCK_TYPE: begin
			if (b == vbd_pkg::TYPE_DATA) begin
				count = '0;
				phase = BLOCK_SIZE;
			end else begin
				phase = PASS_RAW;
				push_expected(b, 1'b1);
			end
		end
		BLOCK_SIZE: begin
			if (shift_size(b)) begin
				remaining = size_acc;
				count = '0;
				phase = (remaining != 0) ? PAYLOAD : BLOCK_TYPE;
			end
		end
		default: push_expected(b, 1'b1);
		endcase
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			fails++;
		end
	endfunction

	function void check_result(logic [7:0] data, logic [31:0] r, logic [7:0] bt,
			logic [7:0] ch, logic raw);
		audio_byte_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: out_byte expected none, got %h (raw_mode %b)", $time, data, raw);
			fails++;
			return;
		end
		want = expected_q.pop_front();
		compare_field("out_byte", {24'h0, want.data}, {24'h0, data});
		compare_field("sample_rate", want.rate, r);
		compare_field("sample_bits", {24'h0, want.bits}, {24'h0, bt});
		compare_field("channel_count", {24'h0, want.chans}, {24'h0, ch});
		compare_field("raw_mode", {31'h0, want.raw}, {31'h0, raw});
	endfunction
endclass

module tb_voc_block_deframer;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic [31:0] sample_rate;
	logic [7:0]  sample_bits;
	logic [7:0]  channel_count;
	logic        raw_mode;

	deframe_scoreboard sb;
	logic [7:0]        stream_q[$];
	int unsigned       send_idle  = 35;
	int unsigned       recv_stall = 47;

	voc_block_deframer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.sample_rate   (sample_rate),
		.sample_bits   (sample_bits),
		.channel_count (channel_count),
		.raw_mode      (raw_mode)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_byte, sample_rate, sample_bits, channel_count, raw_mode);
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic void push_size(int unsigned size);
		stream_q.push_back(size[7:0]);
		stream_q.push_back(size[15:8]);
		stream_q.push_back(size[23:16]);
	endfunction

	function automatic void push_block(int unsigned size);
		stream_q.push_back(vbd_pkg::TYPE_DATA);
		push_size(size);
		repeat (size) stream_q.push_back(rand_byte());
	endfunction

	function automatic void build_stream();
		int unsigned fmt_size;
		int unsigned blk_size;
		logic [7:0]  kind;
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hFF);
		repeat (vbd_pkg::MainHdrLen - 2) stream_q.push_back(rand_byte());
		if ($urandom_range(7) == 0) begin
			do kind = rand_byte(); while (kind == vbd_pkg::TYPE_FORMAT);
			stream_q.push_back(kind);
			while (stream_q.size() < 1000) stream_q.push_back(rand_byte());
			return;
		end
		stream_q.push_back(vbd_pkg::TYPE_FORMAT);
		case ($urandom_range(3))
		0: fmt_size = $urandom_range(11);
		1: fmt_size = vbd_pkg::FmtLen;
		2: fmt_size = vbd_pkg::FmtLen + $urandom_range(1, 40);
		default: fmt_size = vbd_pkg::FmtLen + $urandom_range(256, 511);
		endcase
		push_size(fmt_size);
		repeat (vbd_pkg::FmtLen) stream_q.push_back(rand_byte());
		if (fmt_size > vbd_pkg::FmtLen)
			repeat (fmt_size - vbd_pkg::FmtLen) stream_q.push_back(rand_byte());
		push_block(0);
		push_block(1);
		push_block(0);
		stream_q.push_back(vbd_pkg::TYPE_DATA);
		push_size(4);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hFF);
		stream_q.push_back(vbd_pkg::TYPE_DATA);
		stream_q.push_back(vbd_pkg::TYPE_FORMAT);
		while (stream_q.size() < 1000) begin
			case ($urandom_range(15))
			0, 1: blk_size = 0;
			2: blk_size = $urandom_range(256, 400);
			default: blk_size = $urandom_range(1, 24);
			endcase
			push_block(blk_size);
		end
		if ($urandom_range(1)) begin
			kind = vbd_pkg::TYPE_FORMAT;
		end else begin
			do kind = rand_byte(); while (kind == vbd_pkg::TYPE_DATA);
		end
		stream_q.push_back(kind);
		repeat ($urandom_range(30, 60)) stream_q.push_back(rand_byte());
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(b);
	endtask

	initial begin
		int unsigned idx;
		int unsigned total;
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_byte   = 8'h00;
		out_ready = 1'b0;
		build_stream();
		total = stream_q.size();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (idx = 0; idx < total; idx++) begin
			if (idx < total / 3) begin
				send_idle  = 35;
				recv_stall = 47;
			end else if (idx < 2 * total / 3) begin
				send_idle  = 47;
				recv_stall = 35;
			end else begin
				send_idle  = 0;
				recv_stall = 0;
			end
			send_byte(stream_q[idx]);
		end
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
